/* rtl/rsi_pkg.sv */
// shared types, register codes and saturating helpers for the ray/sphere test
`default_nettype none

package rsi_pkg;

  // configuration register codes
  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_reg_t;

  typedef logic [31:0] word_t;
  typedef word_t [2:0] vec_t;

  // per-ray context that travels down the pipeline
  typedef struct packed {
    vec_t        org;
    vec_t        dir;
    vec_t        d;
    vec_t        pp;
    vec_t        pt;
    logic [61:0] rsq;
    logic        in_sphere;
    logic        miss;
    logic        neg;
  } ctx_t;

  // sign extend a 32 bit word to 64 bits
  function automatic logic signed [63:0] sext(input word_t x);
    return $signed({{32{x[31]}}, x});
  endfunction

  // clamp a 64 bit signed value to the 32 bit signed range
  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // 64 bit signed add with clamping
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) begin
      return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s[63:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/rsi_ray_if.sv */
// ray input channel: valid/ready plus origin and direction
`default_nettype none

interface rsi_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;

  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

`default_nettype wire

/* rtl/rsi_result_if.sv */
// result channel: valid/ready plus hit flag, distance and hit point
`default_nettype none

interface rsi_result_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] hit_distance;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source(output valid, hit, hit_distance, point_x, point_y, point_z,
                 input ready);
  modport sink(input valid, hit, hit_distance, point_x, point_y, point_z,
               output ready);
endinterface

`default_nettype wire

/* rtl/rsi_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturating to 31 bits
`default_nettype none

module rsi_div #(
  parameter int  FRAC_BITS = 16,
  parameter type tag_t     = logic
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  input  tag_t             in_tag,
  output logic             out_vld,
  output logic [30:0]      quo,
  output tag_t             out_tag
);

  localparam int QB = 31;
  localparam int DW = 96;

  logic [DW-1:0] rem   [0:QB-1];
  logic [63:0]   dv    [0:QB-1];
  logic [QB-1:0] qb    [0:QB];
  logic          sat   [0:QB];
  logic          vld   [0:QB];
  tag_t          tag   [0:QB];
  logic [DW-1:0] trial [1:QB];
  logic          ge    [1:QB];
  logic [DW-1:0] num_sh;
  logic [DW-1:0] den_top;

  // scaled numerator and the saturation bound
  assign num_sh  = {32'd0, num} << FRAC_BITS;
  assign den_top = {32'd0, den} << QB;

  // trial subtract for each quotient bit
  always_comb begin
    for (int i = 1; i <= QB; i++) begin
      trial[i] = {32'd0, dv[i-1]} << (QB - i);
      ge[i]    = rem[i-1] >= trial[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QB; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int i = 1; i <= QB; i++) vld[i] <= vld[i-1];
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_sh;
      dv[0]  <= den;
      qb[0]  <= '0;
      sat[0] <= num_sh >= den_top;
      tag[0] <= in_tag;
      for (int i = 1; i <= QB; i++) begin
        qb[i]  <= {qb[i-1][QB-2:0], ge[i]};
        sat[i] <= sat[i-1];
        tag[i] <= tag[i-1];
      end
      for (int i = 1; i < QB; i++) begin
        rem[i] <= ge[i] ? rem[i-1] - trial[i] : rem[i-1];
        dv[i]  <= dv[i-1];
      end
    end
  end

  assign out_vld = vld[QB];
  assign quo     = sat[QB] ? {QB{1'b1}} : qb[QB];
  assign out_tag = tag[QB];

endmodule

`default_nettype wire

/* rtl/rsi_sqrt.sv */
// pipelined floor integer square root, one root bit per stage
`default_nettype none

module rsi_sqrt #(
  parameter int  RAD_W = 64,
  parameter type tag_t = logic
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [RAD_W-1:0] rad,
  input  tag_t                  in_tag,
  output logic                  out_vld,
  output logic [RAD_W/2-1:0]    root,
  output tag_t                  out_tag
);

  localparam int RW = RAD_W / 2;
  localparam int EW = RAD_W + 2;

  logic [EW-1:0] rem   [0:RW-1];
  logic [RW-1:0] rt    [0:RW];
  logic          vld   [0:RW];
  tag_t          tag   [0:RW];
  logic [EW-1:0] trial [1:RW];
  logic          ge    [1:RW];

  // (r + 2^k)^2 - r^2 for each root bit k
  always_comb begin
    for (int i = 1; i <= RW; i++) begin
      trial[i] = ({{(EW-RW){1'b0}}, rt[i-1]} << (RW - i + 1))
               + (EW'(1) << (2 * (RW - i)));
      ge[i]    = rem[i-1] >= trial[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= RW; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int i = 1; i <= RW; i++) vld[i] <= vld[i-1];
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {2'b00, rad};
      rt[0]  <= '0;
      tag[0] <= in_tag;
      for (int i = 1; i <= RW; i++) begin
        rt[i]  <= ge[i] ? (rt[i-1] | (RW'(1) << (RW - i))) : rt[i-1];
        tag[i] <= tag[i-1];
      end
      for (int i = 1; i < RW; i++) begin
        rem[i] <= ge[i] ? rem[i-1] - trial[i] : rem[i-1];
      end
    end
  end

  assign out_vld = vld[RW];
  assign root    = rt[RW];
  assign out_tag = tag[RW];

endmodule

`default_nettype wire

/* rtl/ray_sphere_intersect.sv */
// ray/sphere intersection pipeline, top level
//
// Rays enter on the ray channel (valid/ready); one result word leaves on the
// result channel for every ray, in order. Sphere center and radius are to be
// set through the write port (cfg_we, cfg_index, cfg_data) while the
// pipeline is empty (not enforced). Reset puts the center at the origin and
// the radius at 1.0. A ray can be taken in every cycle unless frozen, and
// passes 4 setup stages, the 32 stage divider for the projection scale, 5
// stages for the perpendicular offset, the 32 stage square root for the half
// chord, 6 stages for the hit point and distance sum, the 33 stage square
// root for the distance, and the output register. When the receiver holds
// ready low with a result waiting, the whole pipeline freezes and ray.ready
// drops in the same cycle; nothing is dropped or repeated. Reset clears all
// valid bits, so the pipeline comes up empty.
`default_nettype none

module ray_sphere_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rsi_ray_if.sink          ray,
  rsi_result_if.source     result
);

  localparam logic [30:0]        RADIUS_RESET = 31'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] MISS_DIST    = -(32'sd1 <<< FRAC_BITS);

  // configuration registers
  rsi_pkg::word_t center_x;
  rsi_pkg::word_t center_y;
  rsi_pkg::word_t center_z;
  logic [30:0]    sphere_radius;
  rsi_pkg::vec_t  ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (rsi_pkg::cfg_reg_t'(cfg_index))
        rsi_pkg::CFG_CENTER_X: center_x      <= cfg_data;
        rsi_pkg::CFG_CENTER_Y: center_y      <= cfg_data;
        rsi_pkg::CFG_CENTER_Z: center_z      <= cfg_data;
        rsi_pkg::CFG_RADIUS:   sphere_radius <= cfg_data[30:0];
      endcase
    end
  end

  assign ctr[0] = center_x;
  assign ctr[1] = center_y;
  assign ctr[2] = center_z;

  // pipeline advances whenever the output register can take a word
  logic en;
  assign en        = !result.valid || result.ready;
  assign ray.ready = en;

  // stage 1: offset from origin to center
  rsi_pkg::ctx_t c0, c1;
  logic          v1;

  always_comb begin
    c0        = '0;
    c0.org[0] = ray.origin_x;
    c0.org[1] = ray.origin_y;
    c0.org[2] = ray.origin_z;
    c0.dir[0] = ray.dir_x;
    c0.dir[1] = ray.dir_y;
    c0.dir[2] = ray.dir_z;
    for (int i = 0; i < 3; i++) begin
      c0.d[i] = rsi_pkg::sat32(rsi_pkg::sext(ctr[i]) - rsi_pkg::sext(c0.org[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) c1 <= c0;
  end

  // stage 2: component products
  rsi_pkg::ctx_t      c2;
  logic               v2;
  logic signed [63:0] pdd [3];
  logic signed [63:0] pdb [3];
  logic signed [63:0] pww [3];
  logic [61:0]        prr;

  always_ff @(posedge clk) begin
    if (en) begin
      c2  <= c1;
      prr <= sphere_radius * sphere_radius;
      for (int i = 0; i < 3; i++) begin
        pdd[i] <= $signed(c1.d[i]) * $signed(c1.d[i]);
        pdb[i] <= $signed(c1.d[i]) * $signed(c1.dir[i]);
        pww[i] <= $signed(c1.dir[i]) * $signed(c1.dir[i]);
      end
    end
  end

  // stage 3: squared lengths and dot product
  rsi_pkg::ctx_t      c3;
  rsi_pkg::ctx_t      c3_next;
  logic               v3;
  logic [63:0]        dsq;
  logic [63:0]        dirsq;
  logic signed [63:0] b;

  always_comb begin
    c3_next     = c2;
    c3_next.rsq = prr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3     <= c3_next;
      dsq    <= $unsigned(pdd[0]) + $unsigned(pdd[1]) + $unsigned(pdd[2]);
      dirsq  <= $unsigned(pww[0]) + $unsigned(pww[1]) + $unsigned(pww[2]);
      b      <= rsi_pkg::sat_add64(rsi_pkg::sat_add64(pdb[0], pdb[1]), pdb[2]);
    end
  end

  // stage 4: early miss, in-sphere test, divider operands
  rsi_pkg::ctx_t c4;
  rsi_pkg::ctx_t c4_next;
  logic          v4;
  logic [63:0]   bmag;
  logic [63:0]   den;

  always_comb begin
    c4_next           = c3;
    c4_next.miss      = (b[63] && dsq > {2'b00, c3.rsq}) || dirsq == 64'd0;
    c4_next.in_sphere = dsq < {2'b00, c3.rsq};
    c4_next.neg       = b[63];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4        <= c4_next;
      bmag      <= b[63] ? (~b + 64'd1) : b;
      den       <= (dirsq == 64'd0) ? 64'd1 : dirsq;
    end
  end

  // projection scale b / |dir|^2
  rsi_pkg::ctx_t cq;
  logic          vq;
  logic [30:0]   q;

  rsi_div #(
    .FRAC_BITS(FRAC_BITS),
    .tag_t    (rsi_pkg::ctx_t)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (v4),
    .num    (bmag),
    .den    (den),
    .in_tag (c4),
    .out_vld(vq),
    .quo    (q),
    .out_tag(cq)
  );

  // stage 5: direction times scale
  logic signed [31:0] sq;
  rsi_pkg::ctx_t      c5;
  logic               v5;
  logic signed [63:0] pms [3];

  assign sq = cq.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (en) begin
      c5 <= cq;
      for (int i = 0; i < 3; i++) pms[i] <= $signed(cq.dir[i]) * sq;
    end
  end

  // stage 6: perpendicular offset from center
  rsi_pkg::ctx_t c6;
  rsi_pkg::ctx_t c6_next;
  logic          v6;

  always_comb begin
    c6_next = c5;
    for (int i = 0; i < 3; i++) begin
      c6_next.pp[i] = rsi_pkg::sat32(
        rsi_pkg::sext(rsi_pkg::sat32(pms[i] >>> FRAC_BITS)) - rsi_pkg::sext(c5.d[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) c6 <= c6_next;
  end

  // stage 7: offset squares
  rsi_pkg::ctx_t      c7;
  logic               v7;
  logic signed [63:0] ppp [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c7 <= c6;
      for (int i = 0; i < 3; i++) ppp[i] <= $signed(c6.pp[i]) * $signed(c6.pp[i]);
    end
  end

  // stage 8: offset squared length
  rsi_pkg::ctx_t c8;
  logic          v8;
  logic [63:0]   ppsq;

  always_ff @(posedge clk) begin
    if (en) begin
      c8   <= c7;
      ppsq <= $unsigned(ppp[0]) + $unsigned(ppp[1]) + $unsigned(ppp[2]);
    end
  end

  // stage 9: offset against radius, half chord squared
  rsi_pkg::ctx_t c9;
  rsi_pkg::ctx_t c9_next;
  logic          v9;
  logic [61:0]   rad;
  logic          far;

  assign far = ppsq > {2'b00, c8.rsq};

  always_comb begin
    c9_next      = c8;
    c9_next.miss = c8.miss || far;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c9      <= c9_next;
      rad     <= far ? '0 : c8.rsq - ppsq[61:0];
    end
  end

  // half chord length
  rsi_pkg::ctx_t ct;
  logic          vt;
  logic [30:0]   t;

  rsi_sqrt #(
    .RAD_W(62),
    .tag_t(rsi_pkg::ctx_t)
  ) u_sqrt_chord (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (v9),
    .rad    (rad),
    .in_tag (c9),
    .out_vld(vt),
    .root   (t),
    .out_tag(ct)
  );

  // stage 10: direction times half chord
  rsi_pkg::ctx_t      c10;
  logic               v10;
  logic signed [63:0] pdt [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c10 <= ct;
      for (int i = 0; i < 3; i++) pdt[i] <= $signed(ct.dir[i]) * $signed({1'b0, t});
    end
  end

  // stage 11: hit point relative to center, near or far side
  rsi_pkg::ctx_t  c11;
  logic           v11;
  rsi_pkg::word_t rel [3];
  rsi_pkg::word_t off [3];

  always_comb begin
    for (int i = 0; i < 3; i++) off[i] = rsi_pkg::sat32(pdt[i] >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c11 <= c10;
      for (int i = 0; i < 3; i++) begin
        rel[i] <= c10.in_sphere
          ? rsi_pkg::sat32(rsi_pkg::sext(c10.pp[i]) + rsi_pkg::sext(off[i]))
          : rsi_pkg::sat32(rsi_pkg::sext(c10.pp[i]) - rsi_pkg::sext(off[i]));
      end
    end
  end

  // stage 12: absolute hit point
  rsi_pkg::ctx_t c12;
  rsi_pkg::ctx_t c12_next;
  logic          v12;

  always_comb begin
    c12_next = c11;
    for (int i = 0; i < 3; i++) begin
      c12_next.pt[i] = rsi_pkg::sat32(rsi_pkg::sext(ctr[i]) + rsi_pkg::sext(rel[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) c12 <= c12_next;
  end

  // stage 13: origin minus hit point
  rsi_pkg::ctx_t  c13;
  logic           v13;
  rsi_pkg::word_t diff [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c13 <= c12;
      for (int i = 0; i < 3; i++) begin
        diff[i] <= rsi_pkg::sat32(rsi_pkg::sext(c12.org[i]) - rsi_pkg::sext(c12.pt[i]));
      end
    end
  end

  // stage 14: difference squares
  rsi_pkg::ctx_t      c14;
  logic               v14;
  logic signed [63:0] pdf [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c14 <= c13;
      for (int i = 0; i < 3; i++) pdf[i] <= $signed(diff[i]) * $signed(diff[i]);
    end
  end

  // stage 15: squared distance
  rsi_pkg::ctx_t c15;
  logic          v15;
  logic [63:0]   dsum;

  always_ff @(posedge clk) begin
    if (en) begin
      c15  <= c14;
      dsum <= $unsigned(pdf[0]) + $unsigned(pdf[1]) + $unsigned(pdf[2]);
    end
  end

  // distance
  rsi_pkg::ctx_t cd;
  logic          vd;
  logic [31:0]   droot;

  rsi_sqrt #(
    .RAD_W(64),
    .tag_t(rsi_pkg::ctx_t)
  ) u_sqrt_dist (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (v15),
    .rad    (dsum),
    .in_tag (c15),
    .out_vld(vd),
    .root   (droot),
    .out_tag(cd)
  );

  // valid bits of the local stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
      v15 <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      v1  <= ray.valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= vq;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= vt;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
      v15 <= v14;
      result.valid <= vd;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (en) begin
      result.hit <= !cd.miss;
      if (cd.miss) begin
        result.hit_distance <= MISS_DIST;
        result.point_x      <= '0;
        result.point_y      <= '0;
        result.point_z      <= '0;
      end else begin
        result.hit_distance <= droot[31] ? 32'h7FFF_FFFF : droot;
        result.point_x      <= cd.pt[0];
        result.point_y      <= cd.pt[1];
        result.point_z      <= cd.pt[2];
      end
    end
  end

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // a hit never reports a negative distance
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hit |-> !result.hit_distance[31])
    else $error("negative distance on a hit");

  // a stall freezes the units along with the local stages
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v4) && $stable(vq) && $stable(vt) && $stable(vd))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench for the ray/sphere intersection pipeline
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 113;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] hit_dist, px, py, pz;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  rsi_pkg::cfg_reg_t cfg_index = rsi_pkg::CFG_CENTER_X;
  logic [31:0] cfg_data = '0;

  rsi_ray_if ray_ch();
  rsi_result_if res_ch();

  ray_sphere_intersect dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .ray(ray_ch.sink), .result(res_ch.source)
  );

  always #5 clk = ~clk;

  // sphere setting as the predictor sees it
  longint sph_c[3];
  longint sph_r;

  ray_t pending_rays[$];
  hit_t expected_hits[$];
  int failures = 0;
  int idle_cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_clamp64(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
    return s;
  endfunction

  // fixed point product, floor rounding, clamped
  function automatic longint fx_mul(longint a, longint b);
    return clamp32((a * b) >>> FRAC);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned len_sq(longint a, longint b, longint c);
    return longint'(a * a) + longint'(b * b) + longint'(c * c);
  endfunction

  // projection scale: (num << FRAC) / den toward zero, clamped to 31 bits
  function automatic longint proj_scale(longint num, longint unsigned den);
    longint unsigned mag, rem, q;
    logic carry, bt;
    mag = num < 0 ? 64'd0 - longint'(num) : num;
    rem = 0;
    q = 0;
    for (int i = 0; i < 64 + FRAC; i++) begin
      bt = i < 64 ? mag[63 - i] : 1'b0;
      carry = rem[63];
      rem = {rem[62:0], bt};
      q <<= 1;
      if (carry || rem >= den) begin
        rem -= den;
        q |= 1;
      end
      if (q > 64'hFFFF_FFFF) q = 64'h1_0000_0000;
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    longint o[3], dv[3], d[3], pp[3], pt[3], df[3];
    longint b, s, off, rel, d_len;
    longint unsigned dsq, rsq, dirsq, ppsq, t;
    bit in_sphere;
    hit_t h;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    dv[0] = r.dx; dv[1] = r.dy; dv[2] = r.dz;
    b = 0;
    for (int i = 0; i < 3; i++) d[i] = clamp32(sph_c[i] - o[i]);
    dsq = len_sq(d[0], d[1], d[2]);
    rsq = sph_r * sph_r;
    for (int i = 0; i < 3; i++) b = add_clamp64(b, d[i] * dv[i]);
    dirsq = len_sq(dv[0], dv[1], dv[2]);
    h.hit = 1'b0;
    h.hit_dist = -(32'sd1 <<< FRAC);
    h.px = 0; h.py = 0; h.pz = 0;
    if ((b < 0 && dsq > rsq) || dirsq == 0) return h;
    s = proj_scale(b, dirsq);
    for (int i = 0; i < 3; i++) pp[i] = clamp32(fx_mul(dv[i], s) - d[i]);
    ppsq = len_sq(pp[0], pp[1], pp[2]);
    if (ppsq > rsq) return h;
    t = int_sqrt(rsq - ppsq);
    in_sphere = dsq < rsq;
    for (int i = 0; i < 3; i++) begin
      off = fx_mul(dv[i], longint'(t));
      rel = in_sphere ? clamp32(pp[i] + off) : clamp32(pp[i] - off);
      pt[i] = clamp32(sph_c[i] + rel);
      df[i] = clamp32(o[i] - pt[i]);
    end
    d_len = longint'(int_sqrt(len_sq(df[0], df[1], df[2])));
    if (d_len > 64'sd2147483647) d_len = 64'sd2147483647;
    h.hit = 1'b1;
    h.hit_dist = d_len[31:0];
    h.px = pt[0][31:0]; h.py = pt[1][31:0]; h.pz = pt[2][31:0];
    return h;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ray driver
  int send_gap = 0;
  bit hold_rays = 1'b0;
  initial begin
    ray_ch.valid = 1'b0;
    {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} = '0;
    {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z} = '0;
  end
  always @(posedge clk) begin
    ray_t r;
    if (!rst) begin
      if (ray_ch.valid && ray_ch.ready) begin
        r.ox = ray_ch.origin_x; r.oy = ray_ch.origin_y; r.oz = ray_ch.origin_z;
        r.dx = ray_ch.dir_x; r.dy = ray_ch.dir_y; r.dz = ray_ch.dir_z;
        expected_hits.push_back(trace_ray(r));
        void'(pending_rays.pop_front());
        send_gap = gap_len();
      end
      if (!(ray_ch.valid && !ray_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          ray_ch.valid <= 1'b0;
        end else if (pending_rays.size() > 0 && !hold_rays) begin
          r = pending_rays[0];
          ray_ch.valid <= 1'b1;
          ray_ch.origin_x <= r.ox; ray_ch.origin_y <= r.oy; ray_ch.origin_z <= r.oz;
          ray_ch.dir_x <= r.dx; ray_ch.dir_y <= r.dy; ray_ch.dir_z <= r.dz;
        end else begin
          ray_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back pressure
  int stall_len = 0;
  initial res_ch.ready = 1'b0;
  always @(posedge clk) begin
    hit_t e;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_hits.size() == 0) begin
          $error("result word with no ray outstanding");
          failures++;
        end else begin
          e = expected_hits.pop_front();
          if (res_ch.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, res_ch.hit);
            failures++;
          end
          if (res_ch.hit_distance !== e.hit_dist) begin
            $error("hit_distance: expected %0d, got %0d", e.hit_dist, res_ch.hit_distance);
            failures++;
          end
          if (res_ch.point_x !== e.px) begin
            $error("point_x: expected %0d, got %0d", e.px, res_ch.point_x);
            failures++;
          end
          if (res_ch.point_y !== e.py) begin
            $error("point_y: expected %0d, got %0d", e.py, res_ch.point_y);
            failures++;
          end
          if (res_ch.point_z !== e.pz) begin
            $error("point_z: expected %0d, got %0d", e.pz, res_ch.point_z);
            failures++;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len--;
        res_ch.ready <= 1'b0;
      end else begin
        stall_len = gap_len();
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (pending_rays.size() == 0 && expected_hits.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(rsi_pkg::cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rsi_pkg::CFG_CENTER_X: sph_c[0] = longint'($signed(val));
      rsi_pkg::CFG_CENTER_Y: sph_c[1] = longint'($signed(val));
      rsi_pkg::CFG_CENTER_Z: sph_c[2] = longint'($signed(val));
      default:               sph_r = val[30:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_rays.size() > 0 || expected_hits.size() > 0 || ray_ch.valid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_sphere(int cx, int cy, int cz, int r);
    write_reg(rsi_pkg::CFG_CENTER_X, cx);
    write_reg(rsi_pkg::CFG_CENTER_Y, cy);
    write_reg(rsi_pkg::CFG_CENTER_Z, cz);
    write_reg(rsi_pkg::CFG_RADIUS, r);
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    return r;
  endfunction

  // unit direction plus a small wobble, aimed near the sphere
  function automatic ray_t aimed_ray(int span);
    ray_t r;
    int axis, sgn;
    axis = $urandom_range(0, 2);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    r.ox = 32'(sph_c[0] + $signed($urandom_range(0, 2 * span)) - span);
    r.oy = 32'(sph_c[1] + $signed($urandom_range(0, 2 * span)) - span);
    r.oz = 32'(sph_c[2] + $signed($urandom_range(0, 2 * span)) - span);
    r.dx = $signed($urandom_range(0, 8000)) - 4000;
    r.dy = $signed($urandom_range(0, 8000)) - 4000;
    r.dz = $signed($urandom_range(0, 8000)) - 4000;
    case (axis)
      0: r.dx = sgn * 65536;
      1: r.dy = sgn * 65536;
      default: r.dz = sgn * 65536;
    endcase
    return r;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    if ($urandom_range(0, 99) < 80) return aimed_ray(int'(sph_r) * 3 + 65536);
    r.ox = any_word(); r.oy = any_word(); r.oz = any_word();
    r.dx = any_word(); r.dy = any_word(); r.dz = any_word();
    return r;
  endfunction

  // stimulus
  initial begin
    sph_c = '{0, 0, 0};
    sph_r = 65536;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed rays against the reset sphere
    pending_rays.push_back(make_ray(0, 0, -3 * 65536, 0, 0, 65536));
    pending_rays.push_back(make_ray(0, 0, 3 * 65536, 0, 0, 65536));
    pending_rays.push_back(make_ray(0, 0, 0, 65536, 0, 0));
    pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0));
    pending_rays.push_back(make_ray(-65536, 0, 0, 65536, 0, 0));
    pending_rays.push_back(make_ray(0, 2 * 65536, -5 * 65536, 0, 0, 65536));
    pending_rays.push_back(make_ray(0, 65536, -5 * 65536, 0, 0, 65536));
    pending_rays.push_back(make_ray(0, 0, -3 * 65536, 0, 0, 2 * 65536));
    pending_rays.push_back(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_rays.push_back(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1));
    pending_rays.push_back(make_ray(0, 0, 32768, 0, 0, -65536));
    for (int i = 0; i < 200; i++) pending_rays.push_back(random_ray());
    // hold the sender until the pipeline has emptied
    while (pending_rays.size() > 0) @(posedge clk);
    hold_rays = 1'b1;
    while (expected_hits.size() > 0) @(posedge clk);
    hold_rays = 1'b0;
    wait_drained();

    // extreme settings, then random ones
    set_sphere(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 31'h7FFF_FFFF);
    pending_rays.push_back(make_ray(0, 0, 0, 65536, 0, 0));
    pending_rays.push_back(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 65536, -65536, 0));
    for (int i = 0; i < 120; i++) pending_rays.push_back(random_ray());
    wait_drained();
    set_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    pending_rays.push_back(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 65536));
    pending_rays.push_back(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    65536, 0, 0));
    for (int i = 0; i < 120; i++) pending_rays.push_back(random_ray());
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      set_sphere($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                 $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                 $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                 $urandom_range(1, 32'h0040_0000));
      for (int i = 0; i < 150; i++) pending_rays.push_back(random_ray());
      wait_drained();
    end

    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
